// ===== hdl/saet_pkg.sv =====
`timescale 1ns / 1ps

package saet_pkg;

    // Default table depths.
    localparam int SAET_SCHEDULE_DEPTH = 64;
    localparam int SAET_ACTIVE_DEPTH   = 64;

    // Field widths fixed by the item formats.
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 7;

    // Command codes carried in an input beat.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_HOLD_TIME  = 1'b0,
        CFG_EXPIRY_TOL = 1'b1
    } saet_cfg_idx_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LD_CMP,
        ST_LD_PUT,
        ST_EX_CHK,
        ST_EX_MOVE,
        ST_REL_RD,
        ST_REL_CHK,
        ST_FINISH
    } saet_state_t;

    // Input beat.
    typedef struct packed {
        logic              command;
        logic [TIME_W-1:0] time_value;
        logic              step_converged;
    } saet_in_t;

    // Result beat.
    typedef struct packed {
        logic [COUNT_W-1:0] inserted_count;
        logic [COUNT_W-1:0] removed_count;
        logic               update_required;
        logic [COUNT_W-1:0] active_count;
        logic               overflow_flag;
    } saet_out_t;

    // Status from the controller to the top level.
    typedef struct packed {
        logic      idle;
        logic      done;
        saet_out_t res;
    } saet_stat_t;

endpackage

// ===== hdl/saet_ram.sv =====
`timescale 1ns / 1ps

module saet_ram
    import saet_pkg::*;
#(
    parameter int DEPTH = SAET_ACTIVE_DEPTH,
    parameter int WIDTH = TIME_W,
    localparam int AW = $clog2(DEPTH)
)(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/saet_ctrl.sv =====
`timescale 1ns / 1ps

module saet_ctrl
    import saet_pkg::*;
#(
    parameter int SCHEDULE_DEPTH = SAET_SCHEDULE_DEPTH,
    parameter int ACTIVE_DEPTH   = SAET_ACTIVE_DEPTH,
    localparam int SAW = $clog2(SCHEDULE_DEPTH),
    localparam int AAW = $clog2(ACTIVE_DEPTH)
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  saet_in_t          item,
    input  logic [TIME_W-1:0] hold_span,
    input  logic [TIME_W-1:0] expiry_tolerance,
    input  logic              res_free,
    output saet_stat_t        stat,
    // Schedule memory port.
    output logic              s_we,
    output logic [SAW-1:0]    s_waddr,
    output logic [TIME_W-1:0] s_wdata,
    output logic              s_re,
    output logic [SAW-1:0]    s_raddr,
    input  logic [TIME_W-1:0] s_rdata,
    // Active memory port.
    output logic              a_we,
    output logic [AAW-1:0]    a_waddr,
    output logic [TIME_W-1:0] a_wdata,
    output logic              a_re,
    output logic [AAW-1:0]    a_raddr,
    input  logic [TIME_W-1:0] a_rdata
);

    localparam int SCW = $clog2(SCHEDULE_DEPTH + 1);
    localparam int ACW = $clog2(ACTIVE_DEPTH + 1);
    localparam logic [SCW-1:0] SCHED_FULL  = SCW'(SCHEDULE_DEPTH);
    localparam logic [ACW-1:0] ACTIVE_FULL = ACW'(ACTIVE_DEPTH);

    saet_state_t       state_reg, state_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [SCW-1:0]    cnt_reg, cnt_next;
    logic [SCW-1:0]    rp_reg, rp_next;
    logic [SCW-1:0]    pos_reg, pos_next;
    logic [ACW-1:0]    total_reg, total_next;
    logic [ACW-1:0]    idx_reg, idx_next;
    logic [ACW-1:0]    ins_reg, ins_next;
    logic [ACW-1:0]    rem_reg, rem_next;
    logic              ovf_reg, ovf_next;
    logic              begun_reg, begun_next;

    // Derived indexes and tests.
    logic              load_refused;
    logic [SCW-1:0]    cnt_m1, pos_m1, pos_m2;
    logic [SCW:0]      rp_p1;
    logic [ACW-1:0]    total_m1;
    logic [ACW:0]      idx_p1;
    logic [TIME_W:0]   rel_sum;
    logic [TIME_W-1:0] rel_expiry;
    logic [TIME_W-1:0] ex_slack;
    logic              expired;
    logic              releasable;
    logic [ACW+COUNT_W-1:0] ins_ext, rem_ext, total_ext;

    assign load_refused = begun_reg || (cnt_reg >= SCHED_FULL);
    assign cnt_m1   = cnt_reg - 1'b1;
    assign pos_m1   = pos_reg - 1'b1;
    assign pos_m2   = pos_reg - SCW'(2);
    assign rp_p1    = {1'b0, rp_reg} + 1'b1;
    assign total_m1 = total_reg - 1'b1;
    assign idx_p1   = {1'b0, idx_reg} + 1'b1;

    // Saturating expiry for a released event.
    assign rel_sum    = {1'b0, s_rdata} + {1'b0, hold_span};
    assign rel_expiry = rel_sum[TIME_W] ? {TIME_W{1'b1}} : rel_sum[TIME_W-1:0];
    assign releasable = (s_rdata <= now_reg);

    // Expiry less tolerance, floored at zero, against the current time.
    assign ex_slack = (a_rdata > expiry_tolerance) ? (a_rdata - expiry_tolerance) : '0;
    assign expired  = (ex_slack <= now_reg);

    assign ins_ext   = {{COUNT_W{1'b0}}, ins_reg};
    assign rem_ext   = {{COUNT_W{1'b0}}, rem_reg};
    assign total_ext = {{COUNT_W{1'b0}}, total_reg};

    // State and datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            rp_reg    <= '0;
            total_reg <= '0;
            begun_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rp_reg    <= rp_next;
            total_reg <= total_next;
            begun_reg <= begun_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg <= now_next;
        pos_reg <= pos_next;
        idx_reg <= idx_next;
        ins_reg <= ins_next;
        rem_reg <= rem_next;
        ovf_reg <= ovf_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (item.command == CMD_LOAD)
                    begin
                        if (load_refused)
                            state_next = ST_FINISH;
                        else if (cnt_reg == '0)
                            state_next = ST_LD_PUT;
                        else
                            state_next = ST_LD_CMP;
                    end
                    else if (item.step_converged && (total_reg != '0))
                        state_next = ST_EX_CHK;
                    else
                        state_next = ST_REL_RD;
                end
            end
            ST_LD_CMP:
            begin
                if ((s_rdata > now_reg) && (pos_reg != SCW'(1)))
                    state_next = ST_LD_CMP;
                else
                    state_next = ST_LD_PUT;
            end
            ST_LD_PUT:
                state_next = ST_FINISH;
            ST_EX_CHK:
            begin
                if (expired)
                    state_next = (idx_reg == total_m1) ? ST_REL_RD : ST_EX_MOVE;
                else if (idx_p1 < {1'b0, total_reg})
                    state_next = ST_EX_CHK;
                else
                    state_next = ST_REL_RD;
            end
            ST_EX_MOVE:
                state_next = ST_EX_CHK;
            ST_REL_RD:
                state_next = (rp_reg < cnt_reg) ? ST_REL_CHK : ST_FINISH;
            ST_REL_CHK:
            begin
                if (releasable && (total_reg < ACTIVE_FULL) && (rp_p1 < {1'b0, cnt_reg}))
                    state_next = ST_REL_CHK;
                else
                    state_next = ST_FINISH;
            end
            ST_FINISH:
                state_next = res_free ? ST_IDLE : ST_FINISH;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Memory accesses and datapath updates.
    always_comb
    begin
        now_next   = now_reg;
        cnt_next   = cnt_reg;
        rp_next    = rp_reg;
        pos_next   = pos_reg;
        total_next = total_reg;
        idx_next   = idx_reg;
        ins_next   = ins_reg;
        rem_next   = rem_reg;
        ovf_next   = ovf_reg;
        begun_next = begun_reg;
        s_we       = 1'b0;
        s_waddr    = '0;
        s_wdata    = '0;
        s_re       = 1'b0;
        s_raddr    = '0;
        a_we       = 1'b0;
        a_waddr    = '0;
        a_wdata    = '0;
        a_re       = 1'b0;
        a_raddr    = '0;
        stat       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                stat.idle = 1'b1;
                if (item_valid)
                begin
                    now_next = item.time_value;
                    ins_next = '0;
                    rem_next = '0;
                    ovf_next = 1'b0;
                    idx_next = '0;
                    if (item.command == CMD_LOAD)
                    begin
                        if (load_refused)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            // Start the compare walk at the tail.
                            pos_next = cnt_reg;
                            if (cnt_reg != '0)
                            begin
                                s_re    = 1'b1;
                                s_raddr = cnt_m1[SAW-1:0];
                            end
                        end
                    end
                    else
                    begin
                        begun_next = 1'b1;
                        if (item.step_converged && (total_reg != '0))
                        begin
                            a_re    = 1'b1;
                            a_raddr = '0;
                        end
                    end
                end
            end
            ST_LD_CMP:
            begin
                // Later times move up one place; fetch the next one down.
                if (s_rdata > now_reg)
                begin
                    s_we     = 1'b1;
                    s_waddr  = pos_reg[SAW-1:0];
                    s_wdata  = s_rdata;
                    pos_next = pos_m1;
                    if (pos_reg != SCW'(1))
                    begin
                        s_re    = 1'b1;
                        s_raddr = pos_m2[SAW-1:0];
                    end
                end
            end
            ST_LD_PUT:
            begin
                s_we     = 1'b1;
                s_waddr  = pos_reg[SAW-1:0];
                s_wdata  = now_reg;
                cnt_next = cnt_reg + 1'b1;
            end
            ST_EX_CHK:
            begin
                if (expired)
                begin
                    rem_next = rem_reg + 1'b1;
                    if (idx_reg == total_m1)
                    begin
                        total_next = total_m1;
                    end
                    else
                    begin
                        // Fetch the last entry to fill the hole.
                        a_re    = 1'b1;
                        a_raddr = total_m1[AAW-1:0];
                    end
                end
                else
                begin
                    idx_next = idx_p1[ACW-1:0];
                    if (idx_p1 < {1'b0, total_reg})
                    begin
                        a_re    = 1'b1;
                        a_raddr = idx_p1[AAW-1:0];
                    end
                end
            end
            ST_EX_MOVE:
            begin
                // The moved entry stays on the read port and is tested next.
                a_we       = 1'b1;
                a_waddr    = idx_reg[AAW-1:0];
                a_wdata    = a_rdata;
                total_next = total_m1;
            end
            ST_REL_RD:
            begin
                if (rp_reg < cnt_reg)
                begin
                    s_re    = 1'b1;
                    s_raddr = rp_reg[SAW-1:0];
                end
            end
            ST_REL_CHK:
            begin
                if (releasable)
                begin
                    if (total_reg >= ACTIVE_FULL)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        a_we       = 1'b1;
                        a_waddr    = total_reg[AAW-1:0];
                        a_wdata    = rel_expiry;
                        total_next = total_reg + 1'b1;
                        rp_next    = rp_p1[SCW-1:0];
                        ins_next   = ins_reg + 1'b1;
                        if (rp_p1 < {1'b0, cnt_reg})
                        begin
                            s_re    = 1'b1;
                            s_raddr = rp_p1[SAW-1:0];
                        end
                    end
                end
            end
            ST_FINISH:
            begin
                stat.done = res_free;
            end
            default:
            begin
                stat.idle = 1'b0;
            end
        endcase

        // Result fields from the finished counters.
        stat.res.inserted_count  = ins_ext[COUNT_W-1:0];
        stat.res.removed_count   = rem_ext[COUNT_W-1:0];
        stat.res.update_required = (ins_reg != '0) || (rem_reg != '0);
        stat.res.active_count    = total_ext[COUNT_W-1:0];
        stat.res.overflow_flag   = ovf_reg;
    end

endmodule

// ===== hdl/scheduled_activation_expiry_table.sv =====
`timescale 1ns / 1ps
// A load shifts up k schedule entries (at most SCHEDULE_DEPTH - 1) before it writes its time;
// a step tests t active entries, moves m entries to fill removed slots and releases r events.
// Throughput: one item at a time; the next beat is taken once the result is registered.
// The walks read one entry per cycle through the registered memories, the expiry walk pausing for each move.
// Reset clears counts, pointers and the started flag; memories need no clearing.

module scheduled_activation_expiry_table
    import saet_pkg::*;
#(
    parameter int SCHEDULE_DEPTH = SAET_SCHEDULE_DEPTH,
    parameter int ACTIVE_DEPTH   = SAET_ACTIVE_DEPTH
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  saet_in_t          item,
    output logic              result_valid,
    input  logic              result_ready,
    output saet_out_t         result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  saet_cfg_idx_t     cfg_index,
    input  logic [TIME_W-1:0] cfg_data
);

    localparam int SAW = $clog2(SCHEDULE_DEPTH);
    localparam int AAW = $clog2(ACTIVE_DEPTH);

    logic [TIME_W-1:0] hold_reg, tol_reg;
    logic              result_valid_reg;
    saet_out_t         result_reg;
    logic              res_free;
    saet_stat_t        stat;

    logic              s_we, s_re, a_we, a_re;
    logic [SAW-1:0]    s_waddr, s_raddr;
    logic [AAW-1:0]    a_waddr, a_raddr;
    logic [TIME_W-1:0] s_wdata, s_rdata, a_wdata, a_rdata;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= '0;
            tol_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_HOLD_TIME:  hold_reg <= cfg_data;
                CFG_EXPIRY_TOL: tol_reg  <= cfg_data;
                default:        hold_reg <= hold_reg;
            endcase
        end
    end

    // Sorted schedule of event times.
    saet_ram #(
        .DEPTH (SCHEDULE_DEPTH),
        .WIDTH (TIME_W)
    ) u_sched_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .re    (s_re),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    // Expiry times of active entries.
    saet_ram #(
        .DEPTH (ACTIVE_DEPTH),
        .WIDTH (TIME_W)
    ) u_active_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .re    (a_re),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    saet_ctrl #(
        .SCHEDULE_DEPTH (SCHEDULE_DEPTH),
        .ACTIVE_DEPTH   (ACTIVE_DEPTH)
    ) u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item             (item),
        .hold_span        (hold_reg),
        .expiry_tolerance (tol_reg),
        .res_free         (res_free),
        .stat             (stat),
        .s_we             (s_we),
        .s_waddr          (s_waddr),
        .s_wdata          (s_wdata),
        .s_re             (s_re),
        .s_raddr          (s_raddr),
        .s_rdata          (s_rdata),
        .a_we             (a_we),
        .a_waddr          (a_waddr),
        .a_wdata          (a_wdata),
        .a_re             (a_re),
        .a_raddr          (a_raddr),
        .a_rdata          (a_rdata)
    );

    assign item_ready = stat.idle;

    // Output register: a finished result waits here while the next beat comes in.
    assign res_free = !result_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (stat.done)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.done)
        begin
            result_reg <= stat.res;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // An accepted beat keeps the controller busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> !item_ready)
        else $error("controller took a second beat back to back");

    // A result is only produced when the output register can take it.
    a_done_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> (!result_valid_reg || result_ready))
        else $error("result overwrote one still waiting");

    // Loads and steps never write both memories in one cycle.
    a_single_writer: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_we && a_we))
        else $error("schedule and active memories written together");

endmodule

// ===== tb/scheduled_activation_expiry_table_tb.sv =====
`timescale 1ns / 1ps

module scheduled_activation_expiry_table_tb;
    import saet_pkg::*;

    localparam int QUIET_LIMIT  = 4000;
    localparam int HOLDOFF_LEN  = 400;
    localparam int PHASE_STEPS  = 66;
    localparam int PHASE_COUNT  = 8;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    logic          clk;
    logic          rst_n;
    logic          item_valid;
    logic          item_ready;
    saet_in_t      item;
    logic          result_valid;
    logic          result_ready;
    saet_out_t     result;
    logic          cfg_valid;
    logic          cfg_ready;
    saet_cfg_idx_t cfg_index;
    logic [TIME_W-1:0] cfg_data;

    scheduled_activation_expiry_table dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Shadow copy of the schedule, the active table and the registers.
    logic [TIME_W-1:0] sched_time [SAET_SCHEDULE_DEPTH];
    logic [TIME_W-1:0] act_expiry [SAET_ACTIVE_DEPTH];
    int                sched_n     = 0;
    int                rel_ptr     = 0;
    int                act_n       = 0;
    bit                steps_begun = 1'b0;
    logic [TIME_W-1:0] hold_q      = '0;
    logic [TIME_W-1:0] tol_q       = '0;

    // Status beats still owed by the block, oldest first.
    saet_out_t awaited_status [$];

    // Traffic shaping shared with the receiver process.
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int holdoff_left  = 0;

    // Run bookkeeping.
    int fail_total    = 0;
    int checked_total = 0;
    int loads_sent    = 0;
    int loads_refused = 0;
    int steps_sent    = 0;
    int peak_active   = 0;
    int quiet_cycles  = 0;
    logic [TIME_W-1:0] step_now = '0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Apply one input beat to the shadow tables and return the status it yields.
    function automatic saet_out_t apply_table_item(input saet_in_t beat);
        saet_out_t         res;
        int                pos;
        int                idx;
        int                ins_n;
        int                rem_n;
        logic              ovf;
        logic [TIME_W-1:0] slack;
        logic [TIME_W:0]   sum;
        res   = '0;
        ins_n = 0;
        rem_n = 0;
        ovf   = 1'b0;
        if (beat.command == CMD_LOAD)
        begin
            if (steps_begun || sched_n >= SAET_SCHEDULE_DEPTH)
                ovf = 1'b1;
            else
            begin
                // Insertion sort; an equal time lands after those already held.
                pos = sched_n;
                while (pos > 0 && sched_time[pos-1] > beat.time_value)
                begin
                    sched_time[pos] = sched_time[pos-1];
                    pos--;
                end
                sched_time[pos] = beat.time_value;
                sched_n++;
            end
        end
        else
        begin
            steps_begun = 1'b1;
            if (beat.step_converged)
            begin
                // A removed slot is refilled from the tail and tested again.
                idx = 0;
                while (idx < act_n)
                begin
                    slack = (act_expiry[idx] > tol_q) ? act_expiry[idx] - tol_q : '0;
                    if (slack <= beat.time_value)
                    begin
                        act_expiry[idx] = act_expiry[act_n-1];
                        act_n--;
                        rem_n++;
                    end
                    else
                        idx++;
                end
            end
            // Release due events in time order until the active table is full.
            while (rel_ptr < sched_n && sched_time[rel_ptr] <= beat.time_value)
            begin
                if (act_n >= SAET_ACTIVE_DEPTH)
                begin
                    ovf = 1'b1;
                    break;
                end
                sum = {1'b0, sched_time[rel_ptr]} + {1'b0, hold_q};
                act_expiry[act_n] = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
                act_n++;
                rel_ptr++;
                ins_n++;
            end
        end
        res.inserted_count  = COUNT_W'(ins_n);
        res.removed_count   = COUNT_W'(rem_n);
        res.update_required = (ins_n > 0 || rem_n > 0);
        res.active_count    = COUNT_W'(act_n);
        res.overflow_flag   = ovf;
        return res;
    endfunction

    function automatic saet_in_t make_beat(input logic cmd, input logic [TIME_W-1:0] t,
                                           input logic conv);
        saet_in_t beat;
        beat.command        = cmd;
        beat.time_value     = t;
        beat.step_converged = conv;
        return beat;
    endfunction

    // Offer one input beat, with random idle cycles ahead of it. Entered and left
    // just after a falling edge; valid stays high on return.
    task automatic send_item(input saet_in_t beat);
        saet_out_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= beat;
        do
            @(posedge clk);
        while (!item_ready);
        res = apply_table_item(beat);
        awaited_status.insert(awaited_status.size(), res);
        if (beat.command == CMD_LOAD)
        begin
            loads_sent++;
            if (res.overflow_flag)
                loads_refused++;
        end
        else
            steps_sent++;
        if (int'(res.active_count) > peak_active)
            peak_active = int'(res.active_count);
        @(negedge clk);
    endtask

    // Stop offering beats and wait until every owed status beat has arrived.
    task automatic wait_for_results();
        item_valid <= 1'b0;
        while (awaited_status.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input saet_cfg_idx_t idx, input logic [TIME_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_HOLD_TIME:  hold_q = val;
            CFG_EXPIRY_TOL: tol_q  = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic compare_field(input string field, input logic [TIME_W-1:0] want,
                                 input logic [TIME_W-1:0] got);
        if (want !== got)
        begin
            $error("%s expected %0d, got %0d", field, want, got);
            fail_total++;
        end
    endtask

    // Receiver: random stalls, plus a long hold-off when one is requested.
    initial
    begin
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Compare each accepted status beat with the oldest expectation.
    always @(posedge clk)
    begin
        saet_out_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (awaited_status.size() == 0)
            begin
                $error("status beat arrived with nothing outstanding");
                fail_total++;
            end
            else
            begin
                want = awaited_status.pop_front();
                compare_field("inserted_count", TIME_W'(want.inserted_count),
                              TIME_W'(result.inserted_count));
                compare_field("removed_count", TIME_W'(want.removed_count),
                              TIME_W'(result.removed_count));
                compare_field("update_required", TIME_W'(want.update_required),
                              TIME_W'(result.update_required));
                compare_field("active_count", TIME_W'(want.active_count),
                              TIME_W'(result.active_count));
                compare_field("overflow_flag", TIME_W'(want.overflow_flag),
                              TIME_W'(result.overflow_flag));
                checked_total++;
            end
        end
    end

    // Watchdog: give up when no beat moves on any channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Loads at the ends of the time range, ties, and the midpoint.
    task automatic test_load_extremes();
        write_reg(CFG_HOLD_TIME, 32'h0008_0000);
        write_reg(CFG_EXPIRY_TOL, 32'h0000_4000);
        send_item(make_beat(CMD_LOAD, 32'h0000_0000, 1'b1));
        send_item(make_beat(CMD_LOAD, TIME_MAX, 1'b0));
        send_item(make_beat(CMD_LOAD, 32'h0001_0000, 1'b0));
        send_item(make_beat(CMD_LOAD, 32'h0001_0000, 1'b1));
        send_item(make_beat(CMD_LOAD, 32'h0000_0001, 1'b0));
        send_item(make_beat(CMD_LOAD, 32'h8000_0000, 1'b0));
        send_item(make_beat(CMD_LOAD, 32'h7FFF_FFFF, 1'b1));
        send_item(make_beat(CMD_LOAD, 32'h0003_0000, 1'b0));
        send_item(make_beat(CMD_LOAD, 32'h0000_0000, 1'b0));
        send_item(make_beat(CMD_LOAD, 32'h0002_8000, 1'b1));
    endtask

    // Fill the schedule with random times, some repeated, then knock on the full one.
    task automatic test_schedule_fill();
        logic [TIME_W-1:0] t;
        int                roll;
        while (sched_n < SAET_SCHEDULE_DEPTH)
        begin
            roll = $urandom_range(99);
            if (roll < 20)
                t = sched_time[$urandom_range(sched_n - 1)];
            else if (roll < 30)
                t = $urandom;
            else
                t = $urandom_range(32'h01C2_0000);
            send_item(make_beat(CMD_LOAD, t, 1'($urandom_range(1))));
        end
        repeat (3)
            send_item(make_beat(CMD_LOAD, $urandom, 1'($urandom_range(1))));
    endtask

    // First steps: release at time zero, a late load, and expiry on and off.
    task automatic test_step_specials();
        send_item(make_beat(CMD_STEP, 32'h0000_0000, 1'b0));
        send_item(make_beat(CMD_LOAD, 32'h0000_0000, 1'b0));
        send_item(make_beat(CMD_STEP, 32'h0000_0000, 1'b1));
        send_item(make_beat(CMD_STEP, 32'h0000_0001, 1'b1));
        send_item(make_beat(CMD_STEP, 32'h0008_0000, 1'b0));
        send_item(make_beat(CMD_STEP, 32'h0008_0000, 1'b1));
        step_now = 32'h0008_0000;
        wait_for_results();
    endtask

    // The receiver holds off for a long stretch while steps keep coming.
    task automatic test_result_backpressure();
        @(posedge clk);
        holdoff_left = HOLDOFF_LEN;
        @(negedge clk);
        repeat (8)
        begin
            step_now = step_now + $urandom_range(32'h0002_0000);
            send_item(make_beat(CMD_STEP, step_now, 1'($urandom_range(1))));
        end
        wait_for_results();
    endtask

    // Random steps under one register setting and one traffic pattern.
    task automatic run_step_phase(input int phase_no);
        logic [TIME_W-1:0] hold_v;
        logic [TIME_W-1:0] tol_v;
        int                done_steps;
        int                roll;
        case (phase_no)
            0:       begin hold_v = 32'h0008_0000; tol_v = 32'h0000_4000; end
            1:       begin hold_v = '0;            tol_v = '0;            end
            2:       begin hold_v = 32'h0014_0000; tol_v = 32'h0002_0000; end
            5:       begin hold_v = TIME_MAX;      tol_v = '0;            end
            6:       begin hold_v = 32'h0003_0000; tol_v = TIME_MAX;      end
            default:
            begin
                hold_v = $urandom_range(32'h0040_0000);
                tol_v  = $urandom_range(32'h0010_0000);
            end
        endcase
        write_reg(CFG_HOLD_TIME, hold_v);
        write_reg(CFG_EXPIRY_TOL, tol_v);
        case (phase_no % 4)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 82; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 82; end
            default: begin send_idle_pct = 18; stall_pct = 18; end
        endcase
        done_steps = 0;
        while (done_steps < PHASE_STEPS)
        begin
            roll = $urandom_range(99);
            if (roll < 3)
                send_item(make_beat(CMD_LOAD, $urandom, 1'($urandom_range(1))));
            else
            begin
                if (roll < 11)
                    send_item(make_beat(CMD_STEP, $urandom_range(step_now),
                                        ($urandom_range(99) < 75)));
                else
                begin
                    step_now = step_now + $urandom_range(32'h0002_0000);
                    send_item(make_beat(CMD_STEP, step_now, ($urandom_range(99) < 75)));
                end
                done_steps++;
            end
        end
        wait_for_results();
    endtask

    task automatic test_random_steps();
        for (int ph = 0; ph < PHASE_COUNT; ph++)
            run_step_phase(ph);
        send_idle_pct = 0;
        stall_pct     = 0;
    endtask

    // Jump to the end of time: release what is left, then expire everything.
    task automatic test_final_flush();
        send_item(make_beat(CMD_STEP, TIME_MAX, 1'b0));
        send_item(make_beat(CMD_STEP, TIME_MAX, 1'b1));
        send_item(make_beat(CMD_LOAD, TIME_MAX, 1'b1));
        send_item(make_beat(CMD_STEP, TIME_MAX, 1'b1));
        wait_for_results();
    endtask

    initial
    begin
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_HOLD_TIME;
        cfg_data   = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_load_extremes();
        test_schedule_fill();
        test_step_specials();
        test_result_backpressure();
        test_random_steps();
        test_final_flush();

        // Let the block settle, then make sure nothing is left owed.
        repeat (20) @(posedge clk);
        if (awaited_status.size() != 0)
        begin
            $error("%0d status beats never arrived", awaited_status.size());
            fail_total++;
        end

        $display("Sent %0d loads (%0d refused) and %0d steps; %0d status beats checked.",
                 loads_sent, loads_refused, steps_sent, checked_total);
        $display("Active table peaked at %0d entries across %0d register settings.",
                 peak_active, PHASE_COUNT + 1);
        if (fail_total == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
